// ===== sv/utd_pkg.sv =====
// Package with the word types and byte-class constants of the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

package utd_pkg;

    // Input word: one byte of the UTF-8 string.
    typedef struct packed {
        logic [7:0] in_byte;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        string_done;
        logic [15:0] unit_count;
        logic        bad_lead;
    } t_out_word;

    // Decoder result for the byte in the input register.
    typedef struct packed {
        logic      has_result;
        t_out_word word;
    } t_dec_res;

    // Continuation bytes still expected.
    localparam logic [1:0] C_PEND_NONE = 2'd0;
    localparam logic [1:0] C_PEND_ONE  = 2'd1;
    localparam logic [1:0] C_PEND_TWO  = 2'd2;

    // Lead byte class boundaries.
    localparam logic [7:0] C_ASCII_END = 8'h80;
    localparam logic [7:0] C_LEAD2_MIN = 8'hC0;
    localparam logic [7:0] C_LEAD3_MIN = 8'hE0;
    localparam logic [7:0] C_LEAD3_END = 8'hF0;

    // Value masks of lead and continuation bytes.
    localparam logic [7:0] C_LEAD2_MASK = 8'h1F;
    localparam logic [7:0] C_LEAD3_MASK = 8'h0F;
    localparam logic [7:0] C_CONT_MASK  = 8'h3F;

    localparam logic [15:0] C_COUNT_MAX = 16'hFFFF;

endpackage

// ===== sv/utd_stream_if.sv =====
// Valid/ready stream interface that carries one word of a given payload type.
`timescale 1ns / 1ps

interface utd_stream_if #(
    parameter type t_payload = logic [7:0]
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/utd_in_reg.sv =====
// Input register stage that holds one UTF-8 byte until the decoder takes it.
`timescale 1ns / 1ps

module utd_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    utd_stream_if.sink          i_byte,
    input  logic                i_take,
    output logic                o_valid,
    output logic [7:0]          o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // The stage is free when empty or when its byte leaves this cycle.
    assign i_byte.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_byte <= i_byte.data.in_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== sv/utd_decode.sv =====
// Decoder state and the single-pass decode of one byte into at most one result word.
`timescale 1ns / 1ps

module utd_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    output utd_pkg::t_dec_res   o_res
);

    logic [1:0]  r_pending;
    logic [9:0]  r_partial;
    logic [15:0] r_units;
    logic        r_error;

    logic [1:0]  n_pending;
    logic [9:0]  n_partial;
    logic [15:0] n_units;
    logic        n_error;

    logic [15:0] acc;
    logic [15:0] units_inc;
    logic        is_zero;

    assign acc       = {r_partial, 6'd0} | {8'd0, i_byte & utd_pkg::C_CONT_MASK};
    assign units_inc = (r_units == utd_pkg::C_COUNT_MAX) ? r_units : r_units + 16'd1;
    assign is_zero   = (i_byte == 8'd0);

    always_comb begin
        n_pending = r_pending;
        n_partial = r_partial;
        n_units   = r_units;
        n_error   = r_error;
        o_res     = '0;
        o_res.word.unit_count = r_units;
        if (r_error) begin
            // Dropping bytes until the terminator.
            if (is_zero) begin
                o_res.has_result       = 1'b1;
                o_res.word.string_done = 1'b1;
                o_res.word.bad_lead    = 1'b1;
                n_pending = utd_pkg::C_PEND_NONE;
                n_partial = '0;
                n_units   = '0;
                n_error   = 1'b0;
            end
        end else if (r_pending != utd_pkg::C_PEND_NONE) begin
            n_pending = r_pending - 2'd1;
            if (r_pending == utd_pkg::C_PEND_ONE) begin
                n_partial = '0;
                n_units   = units_inc;
                o_res.has_result       = 1'b1;
                o_res.word.code_unit   = acc;
                o_res.word.unit_valid  = 1'b1;
                o_res.word.unit_count  = units_inc;
            end else begin
                n_partial = acc[9:0];
            end
        end else if (is_zero) begin
            o_res.has_result       = 1'b1;
            o_res.word.string_done = 1'b1;
            n_partial = '0;
            n_units   = '0;
        end else if (i_byte < utd_pkg::C_ASCII_END) begin
            n_units = units_inc;
            o_res.has_result      = 1'b1;
            o_res.word.code_unit  = {8'd0, i_byte};
            o_res.word.unit_valid = 1'b1;
            o_res.word.unit_count = units_inc;
        end else if (i_byte >= utd_pkg::C_LEAD2_MIN && i_byte < utd_pkg::C_LEAD3_MIN) begin
            n_partial = {2'd0, i_byte & utd_pkg::C_LEAD2_MASK};
            n_pending = utd_pkg::C_PEND_ONE;
        end else if (i_byte >= utd_pkg::C_LEAD3_MIN && i_byte < utd_pkg::C_LEAD3_END) begin
            n_partial = {2'd0, i_byte & utd_pkg::C_LEAD3_MASK};
            n_pending = utd_pkg::C_PEND_TWO;
        end else begin
            n_error = 1'b1;
            o_res.has_result    = 1'b1;
            o_res.word.bad_lead = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= utd_pkg::C_PEND_NONE;
            r_partial <= '0;
            r_units   <= '0;
            r_error   <= 1'b0;
        end else if (i_take) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_units   <= n_units;
            r_error   <= n_error;
        end
    end

`ifndef SYNTHESIS
    // At most two continuation bytes are ever expected.
    a_pending_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("continuation count out of range");

    // While dropping bytes no sequence can be open.
    a_error_no_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error |-> (r_pending == utd_pkg::C_PEND_NONE))
        else $error("sequence open while dropping bytes");

    // A terminator returns every state register to its reset value.
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && o_res.has_result && o_res.word.string_done) |=>
        (r_pending == utd_pkg::C_PEND_NONE && r_partial == 10'd0 &&
         r_units == 16'd0 && !r_error))
        else $error("state not cleared after terminator");

    // The unit count only moves by one, and only with a finished unit.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && !o_res.word.string_done && !$isunknown(r_units)) |=>
        (r_units == $past(r_units) || r_units == $past(r_units) + 16'd1))
        else $error("unit count moved unexpectedly");
`endif

endmodule

// ===== sv/utd_out_reg.sv =====
// Result register that holds one result word until the receiver takes it.
`timescale 1ns / 1ps

module utd_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  utd_pkg::t_out_word   i_word,
    output logic                 o_free,
    utd_stream_if.source         o_unit
);

    logic                r_valid;
    utd_pkg::t_out_word  r_word;

    // A new word may be written when empty or when the held word leaves now.
    assign o_free = !r_valid || o_unit.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_unit.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_unit.valid = r_valid;
    assign o_unit.data  = r_word;

endmodule

// ===== sv/utf8_to_utf16_decoder_core.sv =====
// Top level of the UTF-8 to UTF-16 decoder (Basic Multilingual Plane only).
`timescale 1ns / 1ps

// The block takes a NUL-terminated UTF-8 string on i_byte, one byte per word,
// and gives result words on o_unit. Both channels use valid/ready; a word moves
// at a rising edge where both are high.
// A byte below 0x80 gives a code unit word at once. A two- or three-byte
// sequence gives one code unit word on its last byte and nothing before. An
// invalid lead byte gives one error word with bad_lead set, and later bytes
// are dropped until a zero byte. A zero byte in lead position, or any zero byte
// while dropping, gives a done word carrying the final unit count (saturating
// at 65535), after which the decoder starts a new string.
// A byte is held in the input register, decoded, and its result word is then
// written to the result register. Throughput is one byte per clock while the
// receiver does not hold ready low, bounded by the single decode step between
// the two registers; a byte may be accepted while a result word still waits.
// When the receiver holds ready low, the result register keeps its word, the
// input register keeps the next byte, and i_byte.ready falls once both are full;
// bytes that give no result still pass while the result register is full.
// Reset (i_rst_n low at a rising edge) empties both registers and clears the
// decoder state: no open sequence, zero units, no error.
module utf8_to_utf16_decoder_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    utd_stream_if.sink    i_byte,
    utd_stream_if.source  o_unit
);

    logic               in_valid;
    logic [7:0]         in_byte;
    logic               out_free;
    logic               take;
    utd_pkg::t_dec_res  dec_res;

    // The byte in the input register is decoded when its result, if any, has room.
    assign take = in_valid && (out_free || !dec_res.has_result);

    utd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_take  (take),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    utd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (in_byte),
        .o_res   (dec_res)
    );

    utd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && dec_res.has_result),
        .i_word  (dec_res.word),
        .o_free  (out_free),
        .o_unit  (o_unit)
    );

endmodule

// ===== sim/tb_utf8_to_utf16_decoder_core.sv =====
// Self-checking testbench that streams UTF-8 strings into the decoder core and checks every result word.
`timescale 1ns / 1ps

module tb_utf8_to_utf16_decoder_core;

    // Tracks the decoder state and keeps the result words that are still due, oldest first.
    class utf16_scoreboard;
        utd_pkg::t_out_word unit_words_due[$];
        logic [1:0]  cont_left;
        logic [9:0]  partial_bits;
        logic [15:0] unit_total;
        logic        dropping;
        int          fail_count;

        function new();
            fail_count = 0;
            clear_string();
        endfunction

        function void clear_string();
            cont_left    = utd_pkg::C_PEND_NONE;
            partial_bits = '0;
            unit_total   = '0;
            dropping     = 1'b0;
        endfunction

        function void due_word(logic [15:0] unit, logic valid, logic done, logic bad);
            utd_pkg::t_out_word w;
            w.code_unit   = unit;
            w.unit_valid  = valid;
            w.string_done = done;
            w.unit_count  = unit_total;
            w.bad_lead    = bad;
            unit_words_due.push_back(w);
        endfunction

        function void emit_unit(logic [15:0] unit);
            if (unit_total != utd_pkg::C_COUNT_MAX) begin
                unit_total = unit_total + 16'd1;
            end
            due_word(unit, 1'b1, 1'b0, 1'b0);
        endfunction

        // Advances the decoder state by one accepted byte and queues the word it causes, if any.
        function void decode_byte(logic [7:0] b);
            logic [15:0] gathered;
            if (dropping) begin
                if (b == 8'h00) begin
                    due_word(16'h0000, 1'b0, 1'b1, 1'b1);
                    clear_string();
                end
            end else if (cont_left != utd_pkg::C_PEND_NONE) begin
                // A zero here is just a continuation byte with empty value bits.
                gathered = {partial_bits, b[5:0] & utd_pkg::C_CONT_MASK[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == utd_pkg::C_PEND_NONE) begin
                    partial_bits = '0;
                    emit_unit(gathered);
                end else begin
                    partial_bits = gathered[9:0];
                end
            end else if (b == 8'h00) begin
                due_word(16'h0000, 1'b0, 1'b1, 1'b0);
                clear_string();
            end else if (b < utd_pkg::C_ASCII_END) begin
                emit_unit({8'h00, b});
            end else if (b >= utd_pkg::C_LEAD2_MIN && b < utd_pkg::C_LEAD3_MIN) begin
                partial_bits = {2'b00, b & utd_pkg::C_LEAD2_MASK};
                cont_left    = utd_pkg::C_PEND_ONE;
            end else if (b >= utd_pkg::C_LEAD3_MIN && b < utd_pkg::C_LEAD3_END) begin
                partial_bits = {2'b00, b & utd_pkg::C_LEAD3_MASK};
                cont_left    = utd_pkg::C_PEND_TWO;
            end else begin
                due_word(16'h0000, 1'b0, 1'b0, 1'b1);
                dropping = 1'b1;
            end
        endfunction

        task report(string what);
            $display("%0t: mismatch: %s", $time, what);
            fail_count++;
        endtask

        task check_word(utd_pkg::t_out_word got);
            utd_pkg::t_out_word want;
            if (unit_words_due.size() == 0) begin
                report($sformatf("unexpected word %h", got));
            end else begin
                want = unit_words_due.pop_front();
                if (got.code_unit !== want.code_unit)
                    report($sformatf("code_unit %h, want %h", got.code_unit, want.code_unit));
                if (got.unit_valid !== want.unit_valid)
                    report($sformatf("unit_valid %b, want %b", got.unit_valid, want.unit_valid));
                if (got.string_done !== want.string_done)
                    report($sformatf("string_done %b, want %b", got.string_done,
                                     want.string_done));
                if (got.unit_count !== want.unit_count)
                    report($sformatf("unit_count %0d, want %0d", got.unit_count,
                                     want.unit_count));
                if (got.bad_lead !== want.bad_lead)
                    report($sformatf("bad_lead %b, want %b", got.bad_lead, want.bad_lead));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    utd_stream_if #(.t_payload(utd_pkg::t_in_word))  byte_if ();
    utd_stream_if #(.t_payload(utd_pkg::t_out_word)) unit_if ();

    utf8_to_utf16_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_unit  (unit_if)
    );

    utf16_scoreboard sb = new();

    logic [7:0] utf8_text[$];
    int         burst_left = 0;
    int         bytes_counted = 0;

    int         stall_mode = 0;
    int         mode_left = 0;
    int         rx_phase = 0;

    initial begin
        byte_if.valid = 1'b0;
        byte_if.data  = '0;
        unit_if.ready = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: checks each accepted word and changes its stall pattern now and then.
    always @(posedge i_clk) begin
        if (i_rst_n && unit_if.valid && unit_if.ready) begin
            sb.check_word(unit_if.data);
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        rx_phase++;
        case (stall_mode)
            0: unit_if.ready <= 1'b1;
            1: unit_if.ready <= 1'($urandom_range(0, 1));
            2: unit_if.ready <= (rx_phase % 4) != 0;
            default: unit_if.ready <= (rx_phase % 40) >= 30;
        endcase
    end

    // Sends the bytes in utf8_text in bursts, with gaps that may fall inside a sequence.
    task automatic send_text();
        int gap;
        foreach (utf8_text[k]) begin
            if (burst_left == 0) begin
                gap = 0;
                if ($urandom_range(0, 3) != 0) begin
                    gap = $urandom_range(1, 6);
                end
                if (gap > 0) begin
                    byte_if.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                if ($urandom_range(0, 7) == 0) begin
                    burst_left = $urandom_range(32, 96);
                end else begin
                    burst_left = $urandom_range(1, 12);
                end
            end
            burst_left--;
            byte_if.valid <= 1'b1;
            byte_if.data  <= utd_pkg::t_in_word'(utf8_text[k]);
            do @(posedge i_clk); while (!byte_if.ready);
            sb.decode_byte(utf8_text[k]);
        end
        utf8_text.delete();
    endtask

    // Holds the sender off until every due word has come back.
    task automatic wait_drained();
        byte_if.valid <= 1'b0;
        burst_left = 0;
        while (sb.unit_words_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 7) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Builds one random string: mostly well-formed text, sometimes invalid leads,
    // cut sequences or plain noise.
    task automatic build_string();
        int n_chars;
        int pick;
        int n_noise;
        if ($urandom_range(0, 19) == 0) begin
            n_noise = $urandom_range(1, 10);
            repeat (n_noise) utf8_text.push_back(8'($urandom_range(0, 255)));
            bytes_counted += n_noise;
        end else begin
            n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60)
                                                  : $urandom_range(0, 12);
            for (int c = 0; c < n_chars; c++) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    utf8_text.push_back(8'($urandom_range(1, 127)));
                    bytes_counted += 1;
                end else if (pick < 72) begin
                    utf8_text.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                    utf8_text.push_back(cont_byte());
                    bytes_counted += 2;
                end else if (pick < 92) begin
                    utf8_text.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                    utf8_text.push_back(cont_byte());
                    utf8_text.push_back(cont_byte());
                    bytes_counted += 3;
                end else if (pick < 96) begin
                    // Invalid lead; what follows up to the terminator is dropped.
                    if ($urandom_range(0, 1) == 0) begin
                        utf8_text.push_back(8'($urandom_range(8'h80, 8'hBF)));
                    end else begin
                        utf8_text.push_back(8'($urandom_range(8'hF0, 8'hFF)));
                    end
                    bytes_counted += 1;
                    n_noise = $urandom_range(0, 4);
                    repeat (n_noise) utf8_text.push_back(8'($urandom_range(1, 255)));
                    break;
                end else begin
                    // Three-byte sequence whose tail is a zero byte.
                    utf8_text.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                    utf8_text.push_back(cont_byte());
                    utf8_text.push_back(8'h00);
                    bytes_counted += 3;
                end
            end
        end
        utf8_text.push_back(8'h00);
        bytes_counted += 1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty string, ASCII extremes, two- and three-byte extremes,
        // a zero continuation, and invalid leads at both ends of both ranges.
        utf8_text = '{8'h00,
                      8'h01, 8'h7F,
                      8'hC0, 8'h80, 8'hDF, 8'hBF,
                      8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                      8'hC3, 8'h00,
                      8'h00,
                      8'h80, 8'h41, 8'h00,
                      8'hFF, 8'h00,
                      8'hF0, 8'hE5, 8'h00,
                      8'hBF, 8'h00};
        send_text();
        wait_drained();

        while (bytes_counted < 1200) begin
            build_string();
            send_text();
            if ($urandom_range(0, 24) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.unit_words_due.size() == 0) begin
            $display("tb_utf8_to_utf16_decoder_core OK");
        end else begin
            $display("tb_utf8_to_utf16_decoder_core NOT OK");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_utf8_to_utf16_decoder_core NOT OK");
        $finish;
    end

endmodule
